FILE: hdl/prefix_trie_rule_insert_macros.svh
// Assertion macros for the prefix trie rule loader.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PREFIX_TRIE_RULE_INSERT_MACROS_SVH
`define PREFIX_TRIE_RULE_INSERT_MACROS_SVH

`ifndef SYNTHESIS
// holds at every edge outside reset
`define PTRI_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// antecedent in this cycle implies consequent in the same cycle
`define PTRI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent in this cycle implies consequent in the next cycle
`define PTRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PTRI_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define PTRI_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define PTRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hdl/ptri_pkg.sv
// Shared constants and types for the prefix trie rule loader.
// No dependencies.
package ptri_pkg;

   localparam int POOL_NODES_DEF = 1024;
   localparam int MAX_RULES_DEF  = 128;

   localparam int ADDR_W = 32;
   localparam int LEN_W  = 6;
   localparam int RULE_W = 7;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_WALK  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_ALLOC = 6'b010000,
      ST_MARK  = 6'b100000
   } ptri_state_type;

endpackage

FILE: hdl/prefix_trie_rule_insert.sv
// Binary trie prefix loader: walks/extends a trie in a node pool and marks rule bits.
// Depends on ptri_pkg and prefix_trie_rule_insert_macros.svh.
// Flow: walk the existing path one level at a time (prefix length saturated to 32), check
//   pool space, link one new node per missing level, then mark the rule bit; a refused insert stops after the check.
// A new insert is taken only in idle, after the previous result is loaded; the link memory port is used once a level.
// Reset: synchronous; afterwards a clearing pass zeroes all node links and match rows,
//   during which req_stall stays high.
`include "prefix_trie_rule_insert_macros.svh"

module prefix_trie_rule_insert
   import ptri_pkg::*;
#(
   parameter int POOL_NODES = POOL_NODES_DEF,
   parameter int MAX_RULES  = MAX_RULES_DEF,
   localparam int NODE_W    = $clog2(POOL_NODES),
   localparam int CNT_W     = $clog2(POOL_NODES + 1)
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADDR_W-1:0] req_prefix_addr,
   input  logic [LEN_W-1:0]  req_prefix_len,
   input  logic [RULE_W-1:0] req_rule_index,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [NODE_W-1:0] rsp_end_node,
   output logic              rsp_pool_full,
   output logic [CNT_W-1:0]  rsp_nodes_in_use
);

   localparam logic [NODE_W-1:0] ROOT_NODE = '0;
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(POOL_NODES - 1);

   // node pool storage
   logic [NODE_W-1:0]    left_link_ff  [POOL_NODES];
   logic [NODE_W-1:0]    right_link_ff [POOL_NODES];
   logic [MAX_RULES-1:0] match_row_ff  [POOL_NODES];

   logic [NODE_W-1:0]    rd_left_ff, rd_right_ff;
   logic [MAX_RULES-1:0] rd_match_ff;
   logic [NODE_W-1:0]    rd_addr;

   logic                 left_we, right_we, match_we;
   logic [NODE_W-1:0]    link_wa, link_wd, match_wa;
   logic [MAX_RULES-1:0] match_wd;

   ptri_state_type state_ff, state_in;
   logic [NODE_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [RULE_W-1:0]    rule_ff, rule_in;
   logic [LEN_W-1:0]     level_ff, level_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [CNT_W-1:0]     alloc_ff, alloc_in;
   logic [MAX_RULES-1:0] row_ff, row_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]    rsp_node_ff, rsp_node_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic [CNT_W-1:0]     rsp_cnt_ff, rsp_cnt_in;

   logic                 accept, out_free, rsp_load;
   logic [NODE_W-1:0]    child;
   logic                 has_child;
   logic [CNT_W:0]       need_total;
   logic                 too_many;
   logic [MAX_RULES-1:0] rule_mask;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // address bit of the current level always sits at the top after shifting
   assign child     = addr_ff[ADDR_W-1] ? rd_right_ff : rd_left_ff;
   assign has_child = (child != ROOT_NODE)
                      && ({1'b0, child} < (NODE_W+1)'(POOL_NODES))
                      && (level_ff != len_ff);

   assign need_total = {1'b0, alloc_ff} + (CNT_W+1)'(rem_ff);
   assign too_many   = need_total > (CNT_W+1)'(POOL_NODES);

   // rule 0 is the top bit of the row: MSB first across the whole row
   assign rule_mask = ({1'b0, rule_ff} < (RULE_W+1)'(MAX_RULES))
                      ? ({1'b1, {(MAX_RULES-1){1'b0}}} >> rule_ff) : '0;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      addr_in   = addr_ff;
      len_in    = len_ff;
      rule_in   = rule_ff;
      level_in  = level_ff;
      rem_in    = rem_ff;
      node_in   = node_ff;
      alloc_in  = alloc_ff;
      row_in    = row_ff;
      rd_addr   = node_ff;
      left_we   = 1'b0;
      right_we  = 1'b0;
      link_wa   = node_ff;
      link_wd   = alloc_ff[NODE_W-1:0];
      match_we  = 1'b0;
      match_wa  = node_ff;
      match_wd  = row_ff | rule_mask;
      rsp_load    = 1'b0;
      rsp_node_in = node_ff;
      rsp_full_in = 1'b0;
      rsp_cnt_in  = alloc_ff;
      req_stall   = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            left_we  = 1'b1;
            right_we = 1'b1;
            match_we = 1'b1;
            link_wa  = clr_ff;
            link_wd  = ROOT_NODE;
            match_wa = clr_ff;
            match_wd = '0;
            clr_in   = clr_ff + NODE_W'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            rd_addr   = ROOT_NODE;
            if (req_valid) begin
               addr_in  = req_prefix_addr;
               len_in   = (req_prefix_len > MAX_LEN) ? MAX_LEN : req_prefix_len;
               rule_in  = req_rule_index;
               level_in = '0;
               node_in  = ROOT_NODE;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // read data belongs to node_ff; follow the existing path one level a cycle
            if (has_child) begin
               rd_addr  = child;
               node_in  = child;
               level_in = level_ff + LEN_W'(1);
               addr_in  = {addr_ff[ADDR_W-2:0], 1'b0};
            end else begin
               row_in   = rd_match_ff;
               rem_in   = len_ff - level_ff;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (too_many) begin
               // refused: nothing written
               if (out_free) begin
                  rsp_load    = 1'b1;
                  rsp_node_in = ROOT_NODE;
                  rsp_full_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (rem_ff == '0) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            left_we  = !addr_ff[ADDR_W-1];
            right_we = addr_ff[ADDR_W-1];
            node_in  = alloc_ff[NODE_W-1:0];
            alloc_in = alloc_ff + CNT_W'(1);
            addr_in  = {addr_ff[ADDR_W-2:0], 1'b0};
            rem_in   = rem_ff - LEN_W'(1);
            row_in   = '0;   // fresh node has an empty bitmap
            if (rem_ff == LEN_W'(1)) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            // rewrite is harmless while waiting for the output register
            match_we = 1'b1;
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_link_ff[link_wa] <= link_wd;
      end
      if (right_we) begin
         right_link_ff[link_wa] <= link_wd;
      end
      rd_left_ff  <= left_link_ff[rd_addr];
      rd_right_ff <= right_link_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (match_we) begin
         match_row_ff[match_wa] <= match_wd;
      end
      rd_match_ff <= match_row_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         alloc_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      len_ff   <= len_in;
      rule_ff  <= rule_in;
      level_ff <= level_in;
      rem_ff   <= rem_in;
      node_ff  <= node_in;
      row_ff   <= row_in;
      if (rsp_load) begin
         rsp_node_ff <= rsp_node_in;
         rsp_full_ff <= rsp_full_in;
         rsp_cnt_ff  <= rsp_cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_end_node     = rsp_node_ff;
   assign rsp_pool_full    = rsp_full_ff;
   assign rsp_nodes_in_use = rsp_cnt_ff;

   `PTRI_ASSERT_ALWAYS(a_alloc_bounds, clock, reset,
      (alloc_ff != '0) && ({1'b0, alloc_ff} <= (CNT_W+1)'(POOL_NODES)),
      "node count out of range")
   `PTRI_ASSERT_NEXT(a_alloc_step, clock, reset, state_ff == ST_ALLOC,
      alloc_ff == $past(alloc_ff) + CNT_W'(1), "allocation did not bump count")
   `PTRI_ASSERT_SAME(a_full_root, clock, reset, rsp_valid_ff && rsp_full_ff,
      rsp_node_ff == ROOT_NODE, "refused insert reports non-root node")
   `PTRI_ASSERT_SAME(a_no_accept_busy, clock, reset, accept, state_ff == ST_IDLE,
      "beat accepted outside idle")
   `PTRI_ASSERT_SAME(a_load_free, clock, reset, rsp_load, out_free,
      "result overwrote a pending beat")

endmodule

FILE: sim/tb_prefix_trie_rule_insert.sv
`timescale 1ns / 100ps
// Testbench for prefix_trie_rule_insert: drives rule inserts, predicts each result
// with a trie of its own, and checks every result beat. Depends on ptri_pkg and the RTL.

module tb_prefix_trie_rule_insert;
   import ptri_pkg::*;

   localparam int POOL_NODES = POOL_NODES_DEF;
   localparam int NODE_W     = $clog2(POOL_NODES);
   localparam int CNT_W      = $clog2(POOL_NODES + 1);

   typedef struct packed {
      logic [NODE_W-1:0] end_node;
      logic              pool_full;
      logic [CNT_W-1:0]  nodes_in_use;
   } insert_outcome_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ADDR_W-1:0] req_prefix_addr = '0;
   logic [LEN_W-1:0]  req_prefix_len = '0;
   logic [RULE_W-1:0] req_rule_index = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [NODE_W-1:0] rsp_end_node;
   logic              rsp_pool_full;
   logic [CNT_W-1:0]  rsp_nodes_in_use;

   logic              no_idle = 1'b0;
   int unsigned       mismatch_count = 0;

   // trie copy: link arrays and the bump allocator
   int unsigned       left_links  [POOL_NODES];
   int unsigned       right_links [POOL_NODES];
   int unsigned       alloc_total;

   insert_outcome_type insert_outcomes [$];
   logic [ADDR_W-1:0]  seen_prefixes [$];

   prefix_trie_rule_insert DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_prefix_addr  (req_prefix_addr),
      .req_prefix_len   (req_prefix_len),
      .req_rule_index   (req_rule_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_end_node     (rsp_end_node),
      .rsp_pool_full    (rsp_pool_full),
      .rsp_nodes_in_use (rsp_nodes_in_use)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Follows existing links for up to len levels; returns levels reached.
   function automatic int unsigned trie_descend(input logic [ADDR_W-1:0] addr,
                                                input int unsigned len,
                                                output int unsigned node);
      int unsigned lvl;
      int unsigned child;
      logic        stop;
      node = 0;
      lvl  = 1;
      stop = 1'b0;
      while (lvl <= len && !stop) begin
         child = addr[ADDR_W - lvl] ? right_links[node] : left_links[node];
         if (child == 0 || child >= POOL_NODES) begin
            stop = 1'b1;
         end else begin
            node = child;
            lvl++;
         end
      end
      return lvl - 1;
   endfunction

   function automatic insert_outcome_type apply_rule_insert(input logic [ADDR_W-1:0] addr,
                                                            input logic [LEN_W-1:0] len_raw);
      insert_outcome_type outcome;
      int unsigned        len;
      int unsigned        reached;
      int unsigned        node;
      len = (len_raw > MAX_LEN) ? ADDR_W : len_raw;
      reached = trie_descend(addr, len, node);
      if (alloc_total + (len - reached) > POOL_NODES) begin
         outcome.end_node     = '0;
         outcome.pool_full    = 1'b1;
         outcome.nodes_in_use = CNT_W'(alloc_total);
      end else begin
         for (int unsigned lvl = reached + 1; lvl <= len; lvl++) begin
            if (addr[ADDR_W - lvl])
               right_links[node] = alloc_total;
            else
               left_links[node] = alloc_total;
            node = alloc_total;
            alloc_total++;
         end
         outcome.end_node     = NODE_W'(node);
         outcome.pool_full    = 1'b0;
         outcome.nodes_in_use = CNT_W'(alloc_total);
      end
      return outcome;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   // Sends one rule beat; the prediction is made at the accepting edge.
   task automatic send_rule(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                            input logic [RULE_W-1:0] rule);
      if (!no_idle && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(20, 1)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_prefix_addr <= addr;
      req_prefix_len  <= len;
      req_rule_index  <= rule;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      insert_outcomes.push_back(apply_rule_insert(addr, len));
      seen_prefixes.push_back(addr);
   endtask

   always @(posedge clock) begin : check_results
      insert_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (insert_outcomes.size() == 0) begin
            note_mismatch($sformatf("result beat with nothing pending: node %0d full %0b used %0d",
                                    rsp_end_node, rsp_pool_full, rsp_nodes_in_use));
         end else begin
            want = insert_outcomes.pop_front();
            if (rsp_end_node !== want.end_node)
               note_mismatch($sformatf("end_node exp %0d got %0d",
                                       want.end_node, rsp_end_node));
            if (rsp_pool_full !== want.pool_full)
               note_mismatch($sformatf("pool_full exp %0b got %0b",
                                       want.pool_full, rsp_pool_full));
            if (rsp_nodes_in_use !== want.nodes_in_use)
               note_mismatch($sformatf("nodes_in_use exp %0d got %0d",
                                       want.nodes_in_use, rsp_nodes_in_use));
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 6);
   end

   // Edges of the fields, root inserts, shared paths and saturated lengths.
   task automatic test_directed_extremes();
      send_rule(32'h0000_0000, 6'd0, 7'd0);
      send_rule(32'hFFFF_FFFF, 6'd0, 7'd127);
      send_rule(32'h0000_0000, 6'd32, 7'd0);
      send_rule(32'hFFFF_FFFF, 6'd32, 7'd127);
      send_rule(32'h0000_0000, 6'd32, 7'd1);
      send_rule(32'h0000_0000, 6'd16, 7'd31);
      send_rule(32'h8000_0000, 6'd1, 7'd32);
      send_rule(32'h7FFF_FFFF, 6'd1, 7'd63);
      send_rule(32'hAAAA_AAAA, 6'd33, 7'd64);
      send_rule(32'hAAAA_AAAA, 6'd32, 7'd95);
      send_rule(32'h5555_5555, 6'd63, 7'd96);
      send_rule(32'h5555_5555, 6'd40, 7'd127);
      send_rule(32'hFFFF_0000, 6'd24, 7'd5);
      send_rule(32'hFFFF_00FF, 6'd32, 7'd6);
      send_rule(32'h1234_5678, 6'd8, 7'd100);
      send_rule(32'h1234_5678, 6'd0, 7'd126);
      send_rule(32'h0000_0001, 6'd32, 7'd2);
      send_rule(32'hFFFF_FFFE, 6'd31, 7'd3);
   endtask

   // Mostly prefixes that share a leading part with earlier ones, so walks go deep.
   task automatic test_random_rules(input int count);
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] tail_mask;
      logic [LEN_W-1:0]  len;
      int unsigned       pick;
      int unsigned       keep;
      for (int i = 0; i < count; i++) begin
         no_idle <= (i >= 150 && i < 260);
         pick = $urandom_range(99);
         if (pick < 60) begin
            addr = seen_prefixes[$urandom_range(seen_prefixes.size() - 1)];
            keep = $urandom_range(32);
            if (keep < 32) begin
               tail_mask = 32'hFFFF_FFFF >> keep;
               addr = (addr & ~tail_mask) | ($urandom & tail_mask);
            end
            len = LEN_W'($urandom_range(32));
         end else if (pick < 85) begin
            addr = $urandom;
            len  = LEN_W'($urandom_range(10));
         end else begin
            addr = $urandom;
            len  = LEN_W'($urandom_range(63));
         end
         if ($urandom_range(19) == 0)
            len = LEN_W'($urandom_range(63, 33));
         send_rule(addr, len, RULE_W'($urandom_range(127)));
      end
      no_idle <= 1'b0;
   endtask

   // Fills the pool to the last node, then inserts that do and do not fit.
   task automatic test_pool_exhaustion();
      logic [ADDR_W-1:0] addr;
      int unsigned       reached;
      int unsigned       node;
      int unsigned       spare;
      while (alloc_total < POOL_NODES) begin
         addr    = $urandom;
         reached = trie_descend(addr, ADDR_W, node);
         spare   = POOL_NODES - alloc_total;
         if (reached < ADDR_W)
            send_rule(addr, LEN_W'(reached + ((ADDR_W - reached) < spare ?
                                              (ADDR_W - reached) : spare)),
                      RULE_W'($urandom_range(127)));
      end
      for (int i = 0; i < 4; i++) begin
         addr    = $urandom;
         reached = trie_descend(addr, ADDR_W, node);
         send_rule(addr, LEN_W'(reached < ADDR_W ? reached + 1 : ADDR_W),
                   RULE_W'($urandom_range(127)));
      end
      send_rule($urandom, 6'd0, 7'd127);
      send_rule(32'h0000_0000, 6'd32, 7'd0);
      send_rule(32'hFFFF_FFFF, 6'd63, 7'd64);
      for (int i = 0; i < 8; i++)
         send_rule($urandom, LEN_W'($urandom_range(63)), RULE_W'($urandom_range(127)));
   endtask

   initial begin
      foreach (left_links[i]) begin
         left_links[i]  = 0;
         right_links[i] = 0;
      end
      alloc_total = 1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_random_rules(410);
      test_pool_exhaustion();

      req_valid <= 1'b0;
      while (insert_outcomes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && insert_outcomes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
